// File: design/hdf_pkg.sv
// hdf_pkg: shared types, codes and character helpers for the hex dump formatter
// used by hdf_front, hdf_queue, hdf_back and canonical_hex_dump_formatter
// no dependencies
package hdf_pkg;

   // operation codes of an input beat
   localparam logic [1:0] OP_DATA     = 2'd0;
   localparam logic [1:0] OP_DATA_END = 2'd1;
   localparam logic [1:0] OP_END      = 2'd2;

   // characters per result
   localparam logic [1:0] CNT_ONE = 2'd1;
   localparam logic [1:0] CNT_TWO = 2'd2;

   // line geometry
   localparam logic [4:0] LINE_BYTES = 5'd16;
   localparam logic [3:0] GAP_COL    = 4'd8;

   // segment lengths of the character sequencer
   localparam logic [5:0] OFS_LEN = 6'd10;   // eight digits and two spaces
   localparam logic [5:0] HEX_LEN = 6'd4;    // gap space, two digits, space
   localparam logic [5:0] END_LEN = 6'd2;    // bar and newline
   localparam logic [5:0] TOT_LEN = 6'd9;    // eight digits and newline

   // ascii codes
   localparam logic [6:0] CH_SPACE = 7'h20;
   localparam logic [6:0] CH_BAR   = 7'h7c;
   localparam logic [6:0] CH_NL    = 7'h0a;
   localparam logic [6:0] CH_DOT   = 7'h2e;
   localparam logic [7:0] PRINT_LO = 8'h20;
   localparam logic [7:0] PRINT_HI = 8'h7e;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] data_byte;
   } hdf_req_type;

   typedef struct packed {
      logic [6:0] char_first;
      logic [6:0] char_second;
      logic [1:0] char_count;
      logic       last_of_run;
   } hdf_rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic        has_byte;   // item carries a data byte
      logic [7:0]  data;
      logic [3:0]  col;        // column of the byte within its line
      logic        close;      // line is closed by this item
      logic [4:0]  ncol;       // bytes in the line when it closes
      logic        footer;     // dump ends with this item
      logic [31:0] base;       // byte total before this item
   } hdf_desc_type;

   // sequencer segments
   typedef enum logic [2:0] {
      SEG_IDLE,
      SEG_OFS,
      SEG_HEX,
      SEG_PAD,
      SEG_GUT,
      SEG_END,
      SEG_TOT
   } seg_type;

   // lower-case hex digit
   function automatic logic [6:0] hex_char(input logic [3:0] v);
      logic [6:0] c;
      if (v < 4'd10) begin
         c = 7'h30 + {3'b000, v};
      end else begin
         c = 7'h57 + {3'b000, v};
      end
      return c;
   endfunction

   // gutter character of a line byte
   function automatic logic [6:0] gutter_char(input logic [7:0] b);
      logic [6:0] c;
      if (b >= PRINT_LO && b <= PRINT_HI) begin
         c = b[6:0];
      end else begin
         c = CH_DOT;
      end
      return c;
   endfunction

endpackage

// File: design/hdf_front.sv
// hdf_front: accepts input beats, tracks column and byte total, classifies items
// depends on hdf_pkg; feeds hdf_queue
module hdf_front import hdf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  hdf_req_type  req_payload,
   input  logic         queue_full,
   output logic         push,
   output hdf_desc_type push_desc
);

   logic [3:0]  column_count_ff, column_count_in;
   logic [31:0] byte_total_ff, byte_total_in;
   logic        has_byte;
   logic        footer;
   logic [4:0]  n_after;
   logic        close;

   // classify the beat
   always_comb begin
      has_byte = (req_payload.operation == OP_DATA) ||
                 (req_payload.operation == OP_DATA_END);
      footer   = (req_payload.operation != OP_DATA);
      n_after  = {1'b0, column_count_ff} + {4'b0000, has_byte};
      close    = (has_byte && n_after == LINE_BYTES) || (footer && n_after != 5'd0);

      push_desc.has_byte = has_byte;
      push_desc.data     = req_payload.data_byte;
      push_desc.col      = column_count_ff;
      push_desc.close    = close;
      push_desc.ncol     = n_after;
      push_desc.footer   = footer;
      push_desc.base     = byte_total_ff;

      req_stall = queue_full;
      push      = req_valid && !queue_full;

      column_count_in = column_count_ff;
      byte_total_in   = byte_total_ff;
      if (push) begin
         column_count_in = (close || footer) ? 4'd0 : n_after[3:0];
         byte_total_in   = footer ? 32'd0 : byte_total_ff + {31'd0, has_byte};
      end
   end

   // counters
   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= 4'd0;
         byte_total_ff   <= 32'd0;
      end else begin
         column_count_ff <= column_count_in;
         byte_total_ff   <= byte_total_in;
      end
   end

   // an ended dump leaves the counters clear
   a_footer_clears: assert property (@(posedge clock) disable iff (reset)
      push && footer |=> byte_total_ff == 32'd0 && column_count_ff == 4'd0)
      else $error("counters not cleared after end of dump");

endmodule

// File: design/hdf_queue.sv
// hdf_queue: small fifo of classified items between front and back
// depends on hdf_pkg
module hdf_queue import hdf_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  hdf_desc_type push_desc,
   output logic         full,
   input  logic         pop,
   output hdf_desc_type head_desc,
   output logic         empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   hdf_desc_type     entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // pointers and fill level
   always_comb begin
      full      = (count_ff == FULL_CNT);
      empty     = (count_ff == '0);
      head_desc = entry_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

endmodule

// File: design/hdf_back.sv
// hdf_back: character sequencer, line store and output register
// depends on hdf_pkg; takes items from hdf_queue
module hdf_back import hdf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         queue_empty,
   input  hdf_desc_type head_desc,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output hdf_rsp_type  rsp_payload
);

   typedef struct packed {
      seg_type    seg;
      logic [5:0] idx;
   } pos_type;

   // sequencer state
   seg_type      seg_ff, seg_in;
   logic [5:0]   idx_ff, idx_in;
   hdf_desc_type desc_ff, desc_in;

   // line store
   logic [7:0] line_mem [16];
   logic [7:0] rd0_ff, rd1_ff;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] lit0_ff, lit1_ff, lit0_in, lit1_in;
   logic       gut0_ff, gut1_ff, gut0_in, gut1_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       last_ff, last_in;

   logic        adv;
   logic [4:0]  miss;
   logic [5:0]  pad_len;
   logic [31:0] total;
   pos_type     pos0, pos1, pos2, start;

   // step to the next character position
   function automatic pos_type step_pos(input pos_type p, input hdf_desc_type d,
                                        input logic [5:0] plen);
      pos_type    q;
      logic [5:0] seg_len;
      seg_type    after;
      q       = p;
      seg_len = 6'd1;
      after   = SEG_IDLE;
      case (p.seg)
         SEG_OFS: begin
            seg_len = OFS_LEN;
            after   = SEG_HEX;
         end
         SEG_HEX: begin
            seg_len = HEX_LEN;
            after   = d.close ? SEG_PAD : (d.footer ? SEG_TOT : SEG_IDLE);
         end
         SEG_PAD: begin
            seg_len = plen;
            after   = SEG_GUT;
         end
         SEG_GUT: begin
            seg_len = {1'b0, d.ncol};
            after   = SEG_END;
         end
         SEG_END: begin
            seg_len = END_LEN;
            after   = d.footer ? SEG_TOT : SEG_IDLE;
         end
         SEG_TOT: begin
            seg_len = TOT_LEN;
            after   = SEG_IDLE;
         end
         default: begin
            seg_len = 6'd1;
            after   = SEG_IDLE;
         end
      endcase
      if (p.seg == SEG_IDLE) begin
         q.seg = SEG_IDLE;
         q.idx = 6'd0;
      end else if (p.idx + 6'd1 < seg_len) begin
         q.idx = p.idx + 6'd1;
      end else begin
         q.seg = after;
         q.idx = (after == SEG_HEX && d.col != GAP_COL) ? 6'd1 : 6'd0;
      end
      return q;
   endfunction

   // literal character at a position; gutter bytes come from the store
   function automatic logic [6:0] lit_char(input pos_type p, input hdf_desc_type d,
                                           input logic [5:0] plen,
                                           input logic [31:0] tot);
      logic [6:0] c;
      logic [4:0] sh;
      c  = CH_SPACE;
      sh = {~p.idx[2:0], 2'b00};
      case (p.seg)
         SEG_OFS: begin
            if (p.idx < 6'd8) begin
               c = hex_char(4'(d.base >> sh));
            end
         end
         SEG_HEX: begin
            if (p.idx == 6'd1) begin
               c = hex_char(d.data[7:4]);
            end else if (p.idx == 6'd2) begin
               c = hex_char(d.data[3:0]);
            end
         end
         SEG_PAD: begin
            if (p.idx == plen - 6'd1) begin
               c = CH_BAR;
            end
         end
         SEG_END: begin
            c = (p.idx == 6'd0) ? CH_BAR : CH_NL;
         end
         SEG_TOT: begin
            c = (p.idx < 6'd8) ? hex_char(4'(tot >> sh)) : CH_NL;
         end
         default: begin
            c = CH_SPACE;
         end
      endcase
      return c;
   endfunction

   // sequencer: load an item when idle, else emit up to two characters per beat
   always_comb begin
      adv     = !rsp_valid_ff || !rsp_stall;
      miss    = LINE_BYTES - desc_ff.ncol;
      pad_len = 6'({miss, 1'b0}) + {1'b0, miss} + 6'(desc_ff.ncol <= {1'b0, GAP_COL})
                + 6'd2;
      total   = desc_ff.base + {31'd0, desc_ff.has_byte};

      pos0.seg = seg_ff;
      pos0.idx = idx_ff;
      pos1     = step_pos(pos0, desc_ff, pad_len);
      pos2     = step_pos(pos1, desc_ff, pad_len);

      // first segment of a fresh item
      start.idx = 6'd0;
      if (head_desc.has_byte) begin
         if (head_desc.col == 4'd0) begin
            start.seg = SEG_OFS;
         end else begin
            start.seg = SEG_HEX;
            start.idx = (head_desc.col == GAP_COL) ? 6'd0 : 6'd1;
         end
      end else if (head_desc.close) begin
         start.seg = SEG_PAD;
      end else begin
         start.seg = SEG_TOT;
      end

      pop          = (seg_ff == SEG_IDLE) && !queue_empty;
      seg_in       = seg_ff;
      idx_in       = idx_ff;
      desc_in      = desc_ff;
      rsp_valid_in = rsp_valid_ff;
      lit0_in      = lit0_ff;
      lit1_in      = lit1_ff;
      gut0_in      = gut0_ff;
      gut1_in      = gut1_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;

      if (pop) begin
         seg_in  = start.seg;
         idx_in  = start.idx;
         desc_in = head_desc;
      end

      if (adv) begin
         if (seg_ff != SEG_IDLE) begin
            rsp_valid_in = 1'b1;
            lit0_in      = lit_char(pos0, desc_ff, pad_len, total);
            gut0_in      = (pos0.seg == SEG_GUT);
            if (pos1.seg == SEG_IDLE) begin
               lit1_in = 7'd0;
               gut1_in = 1'b0;
               cnt_in  = CNT_ONE;
               last_in = 1'b1;
               seg_in  = SEG_IDLE;
               idx_in  = 6'd0;
            end else begin
               lit1_in = lit_char(pos1, desc_ff, pad_len, total);
               gut1_in = (pos1.seg == SEG_GUT);
               cnt_in  = CNT_TWO;
               last_in = (pos2.seg == SEG_IDLE);
               seg_in  = pos2.seg;
               idx_in  = pos2.idx;
            end
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff       <= SEG_IDLE;
         idx_ff       <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seg_ff       <= seg_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      lit0_ff <= lit0_in;
      lit1_ff <= lit1_in;
      gut0_ff <= gut0_in;
      gut1_ff <= gut1_in;
      cnt_ff  <= cnt_in;
      last_ff <= last_in;
   end

   // line store: byte written as its item starts, gutter read two at a time
   always_ff @(posedge clock) begin
      if (pop && head_desc.has_byte) begin
         line_mem[head_desc.col] <= head_desc.data;
      end
      if (adv && seg_ff != SEG_IDLE) begin
         rd0_ff <= line_mem[pos0.idx[3:0]];
         rd1_ff <= line_mem[pos1.idx[3:0]];
      end
   end

   // result beat
   always_comb begin
      rsp_valid               = rsp_valid_ff;
      rsp_payload.char_first  = gut0_ff ? gutter_char(rd0_ff) : lit0_ff;
      rsp_payload.char_second = gut1_ff ? gutter_char(rd1_ff) : lit1_ff;
      rsp_payload.char_count  = cnt_ff;
      rsp_payload.last_of_run = last_ff;
   end

   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.char_count == CNT_ONE |-> rsp_payload.last_of_run)
      else $error("single-character beat not last of run");

   a_single_second_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.char_count == CNT_ONE |-> rsp_payload.char_second == 7'd0)
      else $error("unused second character not zero");

   a_count_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.char_count == CNT_ONE || rsp_payload.char_count == CNT_TWO)
      else $error("bad character count");

endmodule

// File: design/canonical_hex_dump_formatter.sv
// canonical_hex_dump_formatter: top level, hexdump -C text two characters per beat
// depends on hdf_pkg, hdf_front, hdf_queue, hdf_back
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid, req_stall | hdf_req_type (operation, data_byte)
//   rsp     | out | rsp_valid, rsp_stall | hdf_rsp_type (two chars, count, last)
//
// the back sequencer loads each item when idle, then emits its result beats, two
// characters per cycle while rsp_stall does not hold it; a mid-line byte yields 2
// beats, a line start 7, a byte that fills a line 12, and a byte that ends the
// dump at column 0 yields 37.
// reset clears the counters, the queue and the sequencer; the line store is not cleared.
// rsp_stall freezes the sequencer; the front keeps taking items until the
// QUEUE_DEPTH-entry queue fills, then raises req_stall.
module canonical_hex_dump_formatter import hdf_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  hdf_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output hdf_rsp_type rsp_payload
);

   hdf_desc_type push_desc, head_desc;
   logic         push, pop, queue_full, queue_empty;

   // front: accept and classify
   hdf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_desc   (push_desc)
   );

   // queue between front and back
   hdf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .full      (queue_full),
      .pop       (pop),
      .head_desc (head_desc),
      .empty     (queue_empty)
   );

   // back: character sequencer
   hdf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_desc   (head_desc),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: bench/testbench.sv
// testbench: self-checking bench for canonical_hex_dump_formatter (hexdump -C text)
// drives a directed table then random dumps, predicts every beat, checks in order
// depends on hdf_pkg and the design sources
`timescale 1ns / 1ps

module testbench;
   import hdf_pkg::*;

   // operation code 3 behaves as an end of dump without a byte
   localparam logic [1:0] OP_END_ALT = 2'd3;

   localparam int TARGET_ITEMS = 253;   // directed rows plus about 230 random
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int HOLD_ITEMS   = 40;    // items offered while the receiver holds off
   localparam int DRAIN_CYCLES = 60;    // quiet time after the last beat
   localparam int QUIET_LIMIT  = 3000;  // cycles without any beat before giving up

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   hdf_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   hdf_rsp_type rsp_payload;

   canonical_hex_dump_formatter uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // formatter state mirrored by the bench
   logic [7:0]  line_store [16];
   int          column_fill = 0;
   logic [31:0] bytes_dumped = '0;

   logic [6:0]  char_stream [$];
   hdf_rsp_type expected_beats [$];

   int mismatches = 0;
   int items_sent = 0;
   int beats_seen = 0;

   // traffic shaping shared between the sender and the receiver
   logic calm        = 1'b0;
   int   hold_asked  = 0;
   int   hold_served = 0;
   int   hold_left   = 0;
   int   quiet       = 0;

   // directed stimulus table
   logic [1:0] row_op [$];
   logic [7:0] row_byte [$];
   string      row_text [$];

   task automatic add_row(input logic [1:0] op, input logic [7:0] b, input string text);
      row_op.push_back(op);
      row_byte.push_back(b);
      row_text.push_back(text);
   endtask

   function automatic logic [6:0] nibble_char(input logic [3:0] v);
      logic [7:0] c;
      if (v < 4'd10) begin
         c = "0" + {4'd0, v};
      end else begin
         c = "a" + {4'd0, v} - 8'd10;
      end
      return c[6:0];
   endfunction

   task automatic put_space(input int n);
      repeat (n) char_stream.push_back(CH_SPACE);
   endtask

   task automatic put_word(input logic [31:0] v);
      for (int sh = 28; sh >= 0; sh -= 4) begin
         char_stream.push_back(nibble_char(v[sh +: 4]));
      end
   endtask

   // padding, gutter and closing bar of the current line
   task automatic close_line();
      logic [7:0] c;
      for (int i = column_fill; i < 16; i++) begin
         if (i == 8) put_space(1);
         put_space(3);
      end
      put_space(1);
      char_stream.push_back(CH_BAR);
      for (int i = 0; i < column_fill; i++) begin
         c = line_store[i];
         char_stream.push_back((c >= 8'h20 && c <= 8'h7e) ? c[6:0] : CH_DOT);
      end
      char_stream.push_back(CH_BAR);
      char_stream.push_back(CH_NL);
      column_fill = 0;
   endtask

   // text caused by one accepted item, with the state update
   task automatic format_item(input logic [1:0] op, input logic [7:0] b);
      char_stream.delete();
      if (op == OP_DATA || op == OP_DATA_END) begin
         if (column_fill == 0) begin
            put_word(bytes_dumped);
            put_space(2);
         end
         if (column_fill == 8) put_space(1);
         char_stream.push_back(nibble_char(b[7:4]));
         char_stream.push_back(nibble_char(b[3:0]));
         put_space(1);
         line_store[column_fill] = b;
         column_fill++;
         bytes_dumped = bytes_dumped + 32'd1;
         if (column_fill == 16) close_line();
      end
      if (op != OP_DATA) begin
         if (column_fill > 0) close_line();
         put_word(bytes_dumped);
         char_stream.push_back(CH_NL);
         column_fill  = 0;
         bytes_dumped = '0;
      end
   endtask

   // pack the character stream two per beat
   task automatic queue_beats();
      hdf_rsp_type beat;
      logic        two;
      for (int i = 0; i < char_stream.size(); i += 2) begin
         two              = (i + 1) < char_stream.size();
         beat.char_first  = char_stream[i];
         beat.char_second = two ? char_stream[i + 1] : 7'd0;
         beat.char_count  = two ? CNT_TWO : CNT_ONE;
         beat.last_of_run = (i + 2) >= char_stream.size();
         expected_beats.push_back(beat);
      end
   endtask

   // offer one item, wait for it to be taken, then predict its beats
   task automatic send_item(input logic [1:0] op, input logic [7:0] b, input string text);
      byte ch;
      while (!calm && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{operation: op, data_byte: b};
      do @(posedge clock); while (req_stall);
      format_item(op, b);
      // typed rows replace the predicted text but keep the state update
      if (text.len() != 0) begin
         char_stream.delete();
         for (int i = 0; i < text.len(); i++) begin
            ch = text[i];
            char_stream.push_back(ch[6:0]);
         end
      end
      queue_beats();
      items_sent++;
   endtask

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("beat %0d: %s got 0x%0h want 0x%0h", beats_seen, what, got, want);
      mismatches++;
   endtask

   // result checker
   always @(posedge clock) begin
      hdf_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            flag_mismatch("unexpected beat", rsp_payload, 0);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_payload.char_first != want.char_first)
               flag_mismatch("char_first", rsp_payload.char_first, want.char_first);
            if (rsp_payload.char_second != want.char_second)
               flag_mismatch("char_second", rsp_payload.char_second, want.char_second);
            if (rsp_payload.char_count != want.char_count)
               flag_mismatch("char_count", rsp_payload.char_count, want.char_count);
            if (rsp_payload.last_of_run != want.last_of_run)
               flag_mismatch("last_of_run", rsp_payload.last_of_run, want.last_of_run);
         end
         beats_seen++;
      end
   end

   // receiver: random stalls, a calm window and one long hold-off
   always @(posedge clock) begin
      if (hold_asked != hold_served) begin
         hold_served <= hold_asked;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 25);
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("canonical_hex_dump_formatter verification failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // stimulus
   initial begin
      int  dump;
      int  len;
      int  pick;
      logic [1:0] ending;

      // empty dumps, line start, printable edges, gap column and a full line
      add_row(OP_END,      8'h00, "00000000\n");
      add_row(OP_END_ALT,  8'h5a, "00000000\n");
      add_row(OP_DATA,     8'hff, "00000000  ff ");
      add_row(OP_DATA,     8'h00, "00 ");
      add_row(OP_DATA,     8'h1f, "");
      add_row(OP_DATA,     8'h20, "");
      add_row(OP_DATA,     8'h7e, "");
      add_row(OP_DATA,     8'h7f, "");
      add_row(OP_DATA,     8'h80, "");
      add_row(OP_DATA,     8'h41, "");
      add_row(OP_DATA,     8'h61, "");
      add_row(OP_DATA,     8'h30, "");
      add_row(OP_DATA,     8'h39, "");
      add_row(OP_DATA,     8'h2e, "");
      add_row(OP_DATA,     8'h7c, "");
      add_row(OP_DATA,     8'h0a, "");
      add_row(OP_DATA,     8'h01, "");
      add_row(OP_DATA,     8'hfe, "");
      // one byte line ending the dump, then a partial line ended by code three
      add_row(OP_DATA_END, 8'h5a, "");
      add_row(OP_DATA,     8'h33, "");
      add_row(OP_END_ALT,  8'haa, "");
      add_row(OP_DATA_END, 8'h00, "");
      add_row(OP_END,      8'h00, "00000000\n");

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < row_op.size(); r++) begin
         send_item(row_op[r], row_byte[r], row_text[r]);
      end

      // random dumps: mostly short, some spanning several lines
      // (offset wrap at 2^32 is far beyond any run length)
      for (dump = 0; items_sent < TARGET_ITEMS; dump++) begin
         if (dump == 2) hold_asked <= hold_asked + 1;
         if (dump == 4) begin
            req_valid <= 1'b0;
            while (expected_beats.size() != 0) @(posedge clock);
         end
         calm <= (dump >= 6 && dump < 12);
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 48) : $urandom_range(0, 20);
         // keep offering during the hold-off so the block fills up
         if (dump == 2) len = HOLD_ITEMS;
         for (int j = 0; j < len; j++) begin
            send_item(OP_DATA, 8'($urandom_range(0, 255)), "");
         end
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            ending = OP_DATA_END;
         end else if (pick < 85) begin
            ending = OP_END;
         end else begin
            ending = OP_END_ALT;
         end
         send_item(ending, 8'($urandom_range(0, 255)), "");
      end

      req_valid <= 1'b0;
      calm      <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("canonical_hex_dump_formatter verification clean");
      end else begin
         $display("canonical_hex_dump_formatter verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
design/hdf_pkg.sv
design/hdf_front.sv
design/hdf_queue.sv
design/hdf_back.sv
design/canonical_hex_dump_formatter.sv
bench/testbench.sv
